/* hw/rtl/dwa_pkg.sv */
// dwa_pkg: shared constants, types and the bit-width helper for the delta
// width analyzer; no dependencies
`timescale 1ns / 1ps

package dwa_pkg;

  localparam int LANE_STRIDE = 16;
  localparam int VALUE_BITS  = 32;
  localparam int WIDTH_BITS  = $clog2(VALUE_BITS + 1);
  localparam int FILL_BITS   = $clog2(LANE_STRIDE + 1);
  localparam int EXTRA_BITS  = WIDTH_BITS + 1;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [WIDTH_BITS-1:0] width_t;
  typedef logic [FILL_BITS-1:0]  fill_t;
  typedef logic [EXTRA_BITS-1:0] extra_t;

  // number of bits up to and including the highest set bit
  function automatic width_t width_of(input value_t v);
    width_t n;
    n = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (v[i]) begin
        n = width_t'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

/* hw/rtl/dwa_if.sv */
// dwa_in_if / dwa_out_if: valid/ready channels of the delta width analyzer
// depends on dwa_pkg
`timescale 1ns / 1ps

interface dwa_in_if;
  logic            valid;
  logic            ready;
  dwa_pkg::value_t value;
  logic            last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface dwa_out_if;
  logic            valid;
  logic            ready;
  dwa_pkg::value_t max_step_one;
  dwa_pkg::width_t width_step_one;
  dwa_pkg::value_t max_step_lane;
  dwa_pkg::width_t width_step_lane;
  dwa_pkg::extra_t extra_bits;

  modport source (output valid, output max_step_one, output width_step_one,
                  output max_step_lane, output width_step_lane, output extra_bits,
                  input ready);
  modport sink   (input valid, input max_step_one, input width_step_one,
                  input max_step_lane, input width_step_lane, input extra_bits,
                  output ready);
endinterface

/* hw/rtl/delta_width_analyzer.sv */
// delta_width_analyzer: block-wise maxima of adjacent and strided wrapped deltas
// depends on dwa_pkg and the channel interfaces in dwa_if.sv
// only a last beat yields a result beat, through the input register, stage 2
// and the result register; one input beat per cycle, a last beat may stall
// reset: synchronous active-low rst_n clears all valids, fill count, running
// maxima; the 16-entry history is not reset, the fill count guards its reads
`timescale 1ns / 1ps

module delta_width_analyzer (
  input  logic             clk,
  input  logic             rst_n,
  dwa_in_if.sink           in_bus,
  dwa_out_if.source        out_bus
);

  // ---------------------------------------------------------------------
  // stage 1: input register
  // ---------------------------------------------------------------------
  logic            s1_valid_r, s1_valid_nxt;
  dwa_pkg::value_t s1_value_r;
  logic            s1_last_r;

  // stage 2: captured block maxima waiting for width calculation
  logic            s2_valid_r, s2_valid_nxt;
  dwa_pkg::value_t s2_max_one_r, s2_max_lane_r;

  // stage 3: result register
  logic            out_valid_r, out_valid_nxt;
  dwa_pkg::value_t out_max_one_r, out_max_lane_r;
  dwa_pkg::width_t out_width_one_r, out_width_lane_r;
  dwa_pkg::extra_t out_extra_r;

  // running block state
  dwa_pkg::value_t history_r [dwa_pkg::LANE_STRIDE];
  dwa_pkg::fill_t  fill_r, fill_nxt;
  dwa_pkg::value_t max_adj_r, max_adj_nxt;
  dwa_pkg::value_t max_str_r, max_str_nxt;

  // handshake between stages
  logic out_stage_ready;
  logic s2_ready;
  logic s2_move;
  logic s1_consume;
  logic in_accept;

  // delta datapath
  dwa_pkg::value_t d_adj, d_str;
  dwa_pkg::value_t adj_upd, str_upd;
  dwa_pkg::width_t w_one, w_lane;

  assign out_stage_ready = !out_valid_r || out_bus.ready;
  assign s2_move         = s2_valid_r && out_stage_ready;
  assign s2_ready        = !s2_valid_r || out_stage_ready;
  // a non-last beat only touches the running state, so it never waits
  assign s1_consume      = s1_valid_r && (!s1_last_r || s2_ready);
  assign in_bus.ready    = !s1_valid_r || s1_consume;
  assign in_accept       = in_bus.valid && in_bus.ready;

  // ---------------------------------------------------------------------
  // delta compare against the adjacent tap and the stride tap
  // ---------------------------------------------------------------------
  always_comb begin
    d_adj   = s1_value_r - history_r[0];
    d_str   = s1_value_r - history_r[dwa_pkg::LANE_STRIDE-1];
    adj_upd = max_adj_r;
    str_upd = max_str_r;
    // first beat of a block has no predecessor
    if ((fill_r >= dwa_pkg::fill_t'(1)) && (d_adj > max_adj_r)) begin
      adj_upd = d_adj;
    end
    if ((fill_r >= dwa_pkg::fill_t'(dwa_pkg::LANE_STRIDE)) && (d_str > max_str_r)) begin
      str_upd = d_str;
    end
  end

  always_comb begin
    fill_nxt    = fill_r;
    max_adj_nxt = max_adj_r;
    max_str_nxt = max_str_r;
    if (s1_consume) begin
      if (s1_last_r) begin
        // block closes: start the next one empty
        fill_nxt    = '0;
        max_adj_nxt = '0;
        max_str_nxt = '0;
      end else begin
        max_adj_nxt = adj_upd;
        max_str_nxt = str_upd;
        if (fill_r < dwa_pkg::fill_t'(dwa_pkg::LANE_STRIDE)) begin
          fill_nxt = fill_r + dwa_pkg::fill_t'(1);
        end
      end
    end
  end

  // history shift line, newest value in entry 0
  always_ff @(posedge clk) begin
    if (s1_consume) begin
      history_r[0] <= s1_value_r;
      for (int i = 1; i < dwa_pkg::LANE_STRIDE; i++) begin
        history_r[i] <= history_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage valids
  // ---------------------------------------------------------------------
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_consume) begin
      s1_valid_nxt = 1'b0;
    end

    s2_valid_nxt = s2_valid_r;
    if (s1_consume && s1_last_r) begin
      s2_valid_nxt = 1'b1;
    end else if (s2_move) begin
      s2_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s2_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fill_r      <= '0;
      max_adj_r   <= '0;
      max_str_r   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
      max_adj_r   <= max_adj_nxt;
      max_str_r   <= max_str_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_value_r <= in_bus.value;
      s1_last_r  <= in_bus.last;
    end
  end

  // last beat: capture the maxima including its own deltas
  always_ff @(posedge clk) begin
    if (s1_consume && s1_last_r) begin
      s2_max_one_r  <= adj_upd;
      s2_max_lane_r <= str_upd;
    end
  end

  // bit counts and their signed difference
  assign w_one  = dwa_pkg::width_of(s2_max_one_r);
  assign w_lane = dwa_pkg::width_of(s2_max_lane_r);

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_max_one_r    <= s2_max_one_r;
      out_max_lane_r   <= s2_max_lane_r;
      out_width_one_r  <= w_one;
      out_width_lane_r <= w_lane;
      out_extra_r      <= {1'b0, w_lane} - {1'b0, w_one};
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.max_step_one    = out_max_one_r;
  assign out_bus.width_step_one  = out_width_one_r;
  assign out_bus.max_step_lane   = out_max_lane_r;
  assign out_bus.width_step_lane = out_width_lane_r;
  assign out_bus.extra_bits      = out_extra_r;

`ifndef SYNTH
  // fill count saturates at the stride
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= dwa_pkg::fill_t'(dwa_pkg::LANE_STRIDE))
    else $error("fill count beyond stride");

  // closing a block empties the running state and loads stage 2
  a_block_close: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_consume && s1_last_r) |=> (fill_r == '0 && max_adj_r == '0 &&
                                   max_str_r == '0 && s2_valid_r))
    else $error("block close did not clear state");

  // a new result beat only comes from a pending stage 2 entry
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_valid_r))
    else $error("result beat without captured maxima");

  // zero width only for a zero maximum
  a_width_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_width_one_r == '0) |-> (out_max_one_r == '0))
    else $error("width zero for nonzero maximum");
`endif

endmodule
